>>> rtl/nnm_pkg.sv
// ----------------------------------------------------------------------------
// nnm_pkg
// Shared constants and helpers for the normal-map pixel pipeline.
// ----------------------------------------------------------------------------
package nnm_pkg;

    localparam int MAX_SIZE   = 4096;
    localparam int NOISE_BITS = 16;
    localparam int CW         = 12;

    localparam logic [0:0] REG_IMAGE_SIZE = 1'b0;
    localparam logic [0:0] REG_AMPLITUDE  = 1'b1;

    localparam logic [31:0] KX0 = 32'd73856093;
    localparam logic [31:0] KY0 = 32'd19349663;
    localparam logic [31:0] KC0 = 32'h1234ABCD;
    localparam logic [31:0] KX1 = 32'd83492791;
    localparam logic [31:0] KY1 = 32'd2971215073;
    localparam logic [31:0] KC1 = 32'hDEADBEEF;
    localparam logic [31:0] HM1 = 32'h27d4eb2d;

    // Shift-and-add multiply by 9 is cheap; this is the first half of the hash.
    function automatic logic [31:0] hash_a(input logic [31:0] v);
        logic [31:0] t;
        t = (v ^ 32'd61) ^ (v >> 16);
        t = t * 32'd9;
        t = t ^ (t >> 4);
        return t;
    endfunction

    function automatic logic [NOISE_BITS-1:0] hash_b(input logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v >> 15);
        return t[31 -: NOISE_BITS];
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [47:0] v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

endpackage

>>> rtl/nnm_noise.sv
// ----------------------------------------------------------------------------
// nnm_noise
// Noise pipeline: wrap neighbours, key multiply, hash, high-pass difference.
// ----------------------------------------------------------------------------
module nnm_noise (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [12:0] i_size,
    input  logic [11:0] i_x,
    input  logic [11:0] i_y,
    output logic        o_valid,
    output logic signed [20:0] o_d0,
    output logic signed [20:0] o_d1
);
    localparam int NB = nnm_pkg::NOISE_BITS;

    // Stage 1: hold size and coordinates; stage 2: wrap the neighbours.
    logic [12:0] n_size;
    logic [11:0] r_sz;
    logic        r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic [11:0] r_px, r_py;
    logic [11:0] r_xs [3];
    logic [11:0] r_ys [3];
    logic [31:0] r_k  [2][9];
    logic [31:0] r_h  [2][9];
    logic [31:0] r_g  [2][9];
    logic [NB-1:0] r_n [2][9];
    logic signed [20:0] r_d [2];

    always_comb begin
        n_size = i_size;
        if (i_size == 13'd0) n_size = 13'd1;
        if (i_size > 13'(nnm_pkg::MAX_SIZE)) n_size = 13'(nnm_pkg::MAX_SIZE);
    end

    // Coordinates reach here already below the size (reduced upstream).
    logic [12:0] xm, xp, ym, yp;
    always_comb begin
        xm = (r_px == 12'd0) ? 13'(r_sz - 12'd1) : 13'(r_px - 12'd1);
        if (r_sz == 12'd0 && r_px == 12'd0) xm = 13'd4095;
        xp = 13'(r_px) + 13'd1;
        if (xp >= {(r_sz == 12'd0), r_sz}) xp = 13'd0;
        ym = (r_py == 12'd0) ? 13'(r_sz - 12'd1) : 13'(r_py - 12'd1);
        if (r_sz == 12'd0 && r_py == 12'd0) ym = 13'd4095;
        yp = 13'(r_py) + 13'd1;
        if (yp >= {(r_sz == 12'd0), r_sz}) yp = 13'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2;
            r_v4 <= r_v3; r_v5 <= r_v4; r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
        r_sz <= n_size[11:0];
        r_px <= i_x;
        r_py <= i_y;
        r_xs[0] <= xm[11:0]; r_xs[1] <= r_px; r_xs[2] <= xp[11:0];
        r_ys[0] <= ym[11:0]; r_ys[1] <= r_py; r_ys[2] <= yp[11:0];
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                r_k[0][j*3+i] <= (32'(r_xs[i]) * nnm_pkg::KX0)
                               ^ (32'(r_ys[j]) * nnm_pkg::KY0) ^ nnm_pkg::KC0;
                r_k[1][j*3+i] <= (32'(r_xs[i]) * nnm_pkg::KX1)
                               ^ (32'(r_ys[j]) * nnm_pkg::KY1) ^ nnm_pkg::KC1;
            end
        end
        for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < 9; k++) begin
                r_h[p][k] <= nnm_pkg::hash_a(r_k[p][k]);
                r_g[p][k] <= r_h[p][k] * nnm_pkg::HM1;
                r_n[p][k] <= nnm_pkg::hash_b(r_g[p][k]);
            end
        end
        for (int p = 0; p < 2; p++) begin
            r_d[p] <= 21'sd9 * $signed({5'd0, r_n[p][4]})
                - $signed(21'(r_n[p][0]) + 21'(r_n[p][1]) + 21'(r_n[p][2])
                + 21'(r_n[p][3]) + 21'(r_n[p][4]) + 21'(r_n[p][5])
                + 21'(r_n[p][6]) + 21'(r_n[p][7]) + 21'(r_n[p][8]));
        end
    end

    assign o_valid = r_v7;
    assign o_d0    = r_d[0];
    assign o_d1    = r_d[1];
endmodule

>>> rtl/nnm_encode.sv
// ----------------------------------------------------------------------------
// nnm_encode
// Gain, byte encode of x/y, pipelined square root and z encode.
// ----------------------------------------------------------------------------
module nnm_encode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic signed [15:0] i_amp,
    input  logic signed [20:0] i_d0,
    input  logic signed [20:0] i_d1,
    output logic        o_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);
    localparam int NB  = nnm_pkg::NOISE_BITS;
    localparam int SQS = 17;
    localparam int NV  = SQS + 5;
    // Floor divide by 9: bias to a positive value, multiply by the reciprocal.
    localparam logic signed [47:0] BIAS  = 48'sd18874368;
    localparam logic signed [47:0] BIASQ = 48'sd2097152;
    localparam logic [26:0]        RECIP9 = 27'd119304648;

    logic [NV-1:0]      r_vv;
    logic signed [36:0] r_p [2];
    logic [25:0]        r_u [2][2];
    logic [52:0]        r_m [2][2];
    logic [7:0]         r_b [2];
    logic signed [18:0] r_q [2];
    logic [35:0]        r_s  [SQS+1];
    logic [35:0]        r_rs [SQS+1];
    logic [7:0]         r_bx [SQS+1][2];

    always_ff @(posedge i_clk) begin
        logic signed [47:0] pw;
        logic signed [47:0] qv;
        logic signed [47:0] s;
        if (!i_rst_n) begin
            r_vv <= '0;
        end else begin
            r_vv <= {r_vv[NV-2:0], i_valid};
        end
        r_p[0] <= 37'(i_amp * i_d0);
        r_p[1] <= 37'(i_amp * i_d1);
        for (int p = 0; p < 2; p++) begin
            pw = 48'(r_p[p]);
            r_u[p][0] <= 26'(((pw * 48'sd255) >>> (NB + 12)) + BIAS);
            r_u[p][1] <= 26'((pw >>> (NB - 5)) + BIAS);
            r_m[p][0] <= 53'(r_u[p][0]) * 53'(RECIP9);
            r_m[p][1] <= 53'(r_u[p][1]) * 53'(RECIP9);
            qv = $signed(48'(r_m[p][0] >> 30)) - BIASQ;
            r_b[p] <= nnm_pkg::clamp8(48'sd128 + qv);
            qv = $signed(48'(r_m[p][1] >> 30)) - BIASQ;
            if (qv > 48'sd131072) qv = 48'sd131072;
            if (qv < -48'sd131072) qv = -48'sd131072;
            r_q[p] <= 19'(qv);
        end
        s = (48'sd1 <<< 32) - 48'(r_q[0]) * 48'(r_q[0]) - 48'(r_q[1]) * 48'(r_q[1]);
        r_s[0]  <= (s > 0) ? 36'(s) : 36'd0;
        r_rs[0] <= '0;
        r_bx[0] <= r_b;
        for (int k = 0; k < SQS; k++) begin
            logic [35:0] bt;
            logic [35:0] ss, rr;
            bt = 36'd1 << (2 * (SQS - 1 - k));
            ss = r_s[k]; rr = r_rs[k];
            if (ss >= rr + bt) begin
                ss = ss - (rr + bt);
                rr = (rr >> 1) + bt;
            end else begin
                rr = rr >> 1;
            end
            r_s[k+1]  <= ss;
            r_rs[k+1] <= rr;
            r_bx[k+1] <= r_bx[k];
        end
    end

    logic [44:0] zb;
    assign zb      = 45'(r_rs[SQS]) * 45'd255;
    assign o_valid = r_vv[NV-1];
    assign o_red   = r_bx[SQS][0];
    assign o_green = r_bx[SQS][1];
    assign o_blue  = nnm_pkg::clamp8(48'sd128 + 48'(zb >> 17));
endmodule

>>> rtl/noise_normal_map_pixel.sv
// ----------------------------------------------------------------------------
// noise_normal_map_pixel
// Procedural normal-map texel from hashed noise with high-pass and tilt.
// ----------------------------------------------------------------------------
// Usage: pulse i_start with i_pixel_x/i_pixel_y while o_busy is low; o_busy
// stays low, so one pixel word enters at every edge with i_start high.
// Pipeline: 13 coordinate stages (input register, then one remainder bit per
// stage for the wrap of x and y), 7 noise stages (hold, wrap neighbours, key
// multiply, hash, hash multiply, hash fold, high-pass sum) and 22 encode
// stages (gain, shift, reciprocal multiply for the divide by 9, clamp,
// z argument, 17 square-root steps).
// Throughput is one pixel per cycle.
// o_strobe marks one cycle of o_red/o_green/o_blue/o_alpha; the receiver
// cannot stall. Reset clears all valid bits and loads image_size 256 and
// amplitude 4096. Write registers with i_cfg_we/i_cfg_index/i_cfg_data only
// when no pixel is in flight.
// ----------------------------------------------------------------------------
module noise_normal_map_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha
);
    localparam int CW = nnm_pkg::CW;

    logic [12:0]        r_size;
    logic signed [15:0] r_amp;
    logic [12:0]        eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 13'd256;
            r_amp  <= 16'sd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nnm_pkg::REG_IMAGE_SIZE: r_size <= i_cfg_data[12:0];
                nnm_pkg::REG_AMPLITUDE:  r_amp  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        eff = r_size;
        if (r_size == 13'd0) eff = 13'd1;
        if (r_size > 13'(nnm_pkg::MAX_SIZE)) eff = 13'(nnm_pkg::MAX_SIZE);
    end

    // Restoring remainder, one quotient bit per stage, for x and y.
    logic [CW:0]  r_v;
    logic [12:0]  r_rx [CW+1];
    logic [12:0]  r_ry [CW+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[CW-1:0], i_start};
        r_rx[0] <= 13'(i_pixel_x);
        r_ry[0] <= 13'(i_pixel_y);
        for (int k = 0; k < CW; k++) begin
            logic [24:0] dv;
            dv = 25'(eff) << (CW - 1 - k);
            r_rx[k+1] <= (25'(r_rx[k]) >= dv) ? 13'(25'(r_rx[k]) - dv) : r_rx[k];
            r_ry[k+1] <= (25'(r_ry[k]) >= dv) ? 13'(25'(r_ry[k]) - dv) : r_ry[k];
        end
    end

    logic               nv;
    logic signed [20:0] d0, d1;

    nnm_noise u_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[CW]),
        .i_size  (r_size),
        .i_x     (r_rx[CW][11:0]),
        .i_y     (r_ry[CW][11:0]),
        .o_valid (nv),
        .o_d0    (d0),
        .o_d1    (d1)
    );

    nnm_encode u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nv),
        .i_amp   (r_amp),
        .i_d0    (d0),
        .i_d1    (d1),
        .o_valid (o_strobe),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    assign o_busy  = 1'b0;
    assign o_alpha = 8'd255;

    a_busy_low: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_blue_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_blue >= 8'd128)
        else $error("blue below midpoint");
    a_alpha_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_alpha == 8'd255)
        else $error("alpha not opaque");
endmodule
